/* src/byte_literal_token_parser_macros.svh */
// assertion macros for the byte literal token parser
// no dependencies; included by modules that carry concurrent checks
`ifndef BYTE_LITERAL_TOKEN_PARSER_MACROS_SVH
`define BYTE_LITERAL_TOKEN_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define BLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define BLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/blp_pkg.sv */
// shared types, character codes and helpers of the byte literal token parser
// no dependencies
package blp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 8;
    localparam int ACC_W   = 9;
    localparam int NIB_W   = 4;

    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'd34;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'd47;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'd58;
    localparam logic [CHAR_W-1:0] CHAR_LX    = 8'd120;
    localparam logic [CHAR_W-1:0] CHAR_UX    = 8'd88;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'd70;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd102;
    localparam logic [11:0]       DEC_LIMIT  = 12'd255;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [VALUE_W-1:0] ERR_CHAR  = 8'd0;
    localparam logic [VALUE_W-1:0] ERR_HEX   = 8'd1;
    localparam logic [VALUE_W-1:0] ERR_RANGE = 8'd2;
    localparam logic [VALUE_W-1:0] ERR_OPEN  = 8'd3;

    typedef enum logic [8:0] {
        MODE_IDLE    = 9'b000000001,
        MODE_STRING  = 9'b000000010,
        MODE_SLASH   = 9'b000000100,
        MODE_COMMENT = 9'b000001000,
        MODE_ZERO    = 9'b000010000,
        MODE_DECIMAL = 9'b000100000,
        MODE_HEX1    = 9'b001000000,
        MODE_HEX2    = 9'b010000000,
        MODE_ERROR   = 9'b100000000
    } t_mode;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c > CHAR_SLASH) && (c < CHAR_COLON);
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [NIB_W:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = 8'd0;
        if (is_digit(c)) begin
            t = c - CHAR_ZERO;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            t = c - CHAR_UA + 8'd10;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            t = c - CHAR_LA + 8'd10;
        end else begin
            t = 8'd16;
        end
        return t[NIB_W:0];
    endfunction

endpackage

/* src/blp_in_if.sv */
// input character channel of the byte literal token parser
// depends on blp_pkg
interface blp_in_if import blp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

/* src/blp_out_if.sv */
// result channel of the byte literal token parser
// depends on blp_pkg
interface blp_out_if import blp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               out_kind;
    logic [VALUE_W-1:0] out_value;
    logic               out_last;

    modport source (output valid, output out_kind, output out_value, output out_last,
                    input ready);
    modport sink   (input valid, input out_kind, input out_value, input out_last,
                    output ready);
endinterface

/* src/byte_literal_token_parser.sv */
// byte literal token parser: characters in, data bytes and error reports out
// depends on blp_pkg, blp_in_if, blp_out_if and byte_literal_token_parser_macros.svh
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    in_char
//   o_out     out   valid/ready    out_kind, out_value, out_last
//
// one character is parsed per cycle while i_in.ready is high; its results (none, one or two) land in a
// two-slot result buffer in the same edge and leave one per cycle while o_out is ready.
// a character that ends a decimal run with an error fills both slots and holds
// the input until the first of them has left; any other gives one result at most, so a
// transaction can be taken every cycle while o_out is ready.
// i_rst_n is synchronous, active low; it clears parse state and the buffer.
// a character is taken while the buffer is empty or its last entry is leaving.
`include "byte_literal_token_parser_macros.svh"

module byte_literal_token_parser import blp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    blp_in_if.sink    i_in,
    blp_out_if.source o_out
);

    typedef struct packed {
        t_mode            mode;
        logic [ACC_W-1:0] acc;
        logic             err;
    } t_idle;

    // token start from the between-tokens state
    function automatic t_idle idle_step(input logic [CHAR_W-1:0] c, input logic [ACC_W-1:0] acc);
        t_idle r;
        r.mode = MODE_IDLE;
        r.acc  = acc;
        r.err  = 1'b0;
        if (c == CHAR_SPACE || c == CHAR_NL) begin
            r.mode = MODE_IDLE;
        end else if (c == CHAR_QUOTE) begin
            r.mode = MODE_STRING;
        end else if (c == CHAR_SLASH) begin
            r.mode = MODE_SLASH;
        end else if (c == CHAR_ZERO) begin
            r.acc  = '0;
            r.mode = MODE_ZERO;
        end else if (is_digit(c)) begin
            r.acc  = ACC_W'(c - CHAR_ZERO);
            r.mode = MODE_DECIMAL;
        end else begin
            r.mode = MODE_ERROR;
            r.err  = 1'b1;
        end
        return r;
    endfunction

    t_mode            r_mode, n_mode;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [NIB_W-1:0] r_nib, n_nib;
    t_result          r_slot [2];
    logic [1:0]       r_count;

    t_result          res0, res1;
    logic [1:0]       res_count;
    logic             accept, pop;
    logic [CHAR_W-1:0] c;
    logic [NIB_W:0]   hv;
    logic [11:0]      dec_sum;
    t_idle            idle;

    assign c       = i_in.in_char;
    assign hv      = hex_value(c);
    assign dec_sum = 12'(r_acc) * 12'd10 + 12'(c - CHAR_ZERO);
    assign idle    = idle_step(c, r_acc);

    assign pop        = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count == 2'd0) || (r_count == 2'd1 && o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_nib     = r_nib;
        res0      = '{kind: KIND_DATA, value: '0, last: 1'b1};
        res1      = '{kind: KIND_ERROR, value: ERR_CHAR, last: 1'b1};
        res_count = 2'd0;
        unique case (r_mode)
            MODE_ERROR: begin
            end
            MODE_STRING: begin
                if (c == CHAR_QUOTE) begin
                    n_mode = MODE_IDLE;
                end else if (c == CHAR_NL) begin
                    n_mode    = MODE_ERROR;
                    res0      = '{kind: KIND_ERROR, value: ERR_OPEN, last: 1'b1};
                    res_count = 2'd1;
                end else begin
                    res0      = '{kind: KIND_DATA, value: c, last: 1'b1};
                    res_count = 2'd1;
                end
            end
            MODE_SLASH: begin
                if (c == CHAR_SLASH) begin
                    n_mode = MODE_COMMENT;
                end else begin
                    n_mode    = MODE_ERROR;
                    res0      = '{kind: KIND_ERROR, value: ERR_CHAR, last: 1'b1};
                    res_count = 2'd1;
                end
            end
            MODE_COMMENT: begin
                if (c == CHAR_NL) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_ZERO, MODE_DECIMAL: begin
                if (r_mode == MODE_ZERO && (c == CHAR_LX || c == CHAR_UX)) begin
                    n_mode = MODE_HEX1;
                end else if (is_digit(c)) begin
                    if (dec_sum >= DEC_LIMIT) begin
                        n_mode    = MODE_ERROR;
                        res0      = '{kind: KIND_ERROR, value: ERR_RANGE, last: 1'b1};
                        res_count = 2'd1;
                    end else begin
                        n_acc  = dec_sum[ACC_W-1:0];
                        n_mode = MODE_DECIMAL;
                    end
                end else begin
                    // run ends: emit its byte, then reparse this character
                    res0   = '{kind: KIND_DATA, value: r_acc[VALUE_W-1:0], last: !idle.err};
                    n_mode = idle.mode;
                    n_acc  = idle.acc;
                    res_count = idle.err ? 2'd2 : 2'd1;
                end
            end
            MODE_HEX1: begin
                if (!hv[NIB_W]) begin
                    n_nib  = hv[NIB_W-1:0];
                    n_mode = MODE_HEX2;
                end else begin
                    n_mode    = MODE_ERROR;
                    res0      = '{kind: KIND_ERROR, value: ERR_HEX, last: 1'b1};
                    res_count = 2'd1;
                end
            end
            MODE_HEX2: begin
                if (!hv[NIB_W]) begin
                    n_mode    = MODE_IDLE;
                    res0      = '{kind: KIND_DATA, value: {r_nib, hv[NIB_W-1:0]}, last: 1'b1};
                    res_count = 2'd1;
                end else begin
                    n_mode    = MODE_ERROR;
                    res0      = '{kind: KIND_ERROR, value: ERR_HEX, last: 1'b1};
                    res_count = 2'd1;
                end
            end
            MODE_IDLE: begin
                n_mode = idle.mode;
                n_acc  = idle.acc;
                if (idle.err) begin
                    res0      = '{kind: KIND_ERROR, value: ERR_CHAR, last: 1'b1};
                    res_count = 2'd1;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= '0;
            r_nib   <= '0;
            r_count <= 2'd0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_acc   <= n_acc;
                r_nib   <= n_nib;
                // older results have drained by this edge when a transaction is taken
                r_count <= res_count;
            end else if (pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[0] <= res0;
            r_slot[1] <= res1;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
        end
    end

    assign o_out.valid     = (r_count != 2'd0);
    assign o_out.out_kind  = r_slot[0].kind;
    assign o_out.out_value = r_slot[0].value;
    assign o_out.out_last  = r_slot[0].last;

    `BLP_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, accept, (r_count == 2'd0) || pop,
        "input taken while results still pending")
    `BLP_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, r_mode == MODE_ERROR,
        r_mode == MODE_ERROR && !(o_out.valid && $past(accept)),
        "parser left error state or emitted after error")
    `BLP_ASSERT_NOW(a_pair_order, i_clk, i_rst_n, r_count == 2'd2,
        !r_slot[0].last && r_slot[1].last && r_slot[1].kind == KIND_ERROR,
        "two-result pair malformed")
    `BLP_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count != 2'd3,
        "result buffer count out of range")

endmodule
